### hw/rtl/tsls_pkg.sv
// ----------------------------------------------------------------------------
// tsls_pkg
// Shared types and constants for the tour swap local search block: item
// kinds, register indexes, field widths and the controller/datapath structs.
// ----------------------------------------------------------------------------
package tsls_pkg;

    // field widths
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 10;
    localparam int DIST_W  = 8;
    localparam int COST_W  = 18;
    localparam int CITY_W  = 10;
    localparam int NUM_W   = 11;
    localparam int LIM_W   = 10;
    localparam int STALL_W = 11;
    localparam int CFG_IDX_W = 1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_DIST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_TOUR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TRY       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_KICK      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ_BEST = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CITIES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 1'b1;

    // reset values and saturation limits
    localparam logic [NUM_W-1:0]   NUM_CITIES_RST  = 11'd1024;
    localparam logic [LIM_W-1:0]   STALL_LIMIT_RST = 10'd50;
    localparam logic [COST_W-1:0]  COST_MAX        = 18'h3FFFF;
    localparam logic [STALL_W-1:0] STALL_MAX       = 11'h7FF;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic wr_dist;
        logic wr_tour;
        logic walk_issue;
        logic pos_clear;
        logic start_commit;
        logic try_commit;
        logic try_fail;
        logic swap_rd_a;
        logic swap_rd_b;
        logic swap_wr_a;
        logic swap_wr_b;
        logic copy_issue;
        logic rd_best;
        logic result_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic kick_ok;
        logic last_pos;
        logic copy_last;
        logic pipe_busy;
        logic lt_current;
        logic copy_pend;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/tsls_dp.sv
// ----------------------------------------------------------------------------
// tsls_dp
// Datapath: distance, current tour and best tour memories, the tour walk
// pipeline with cost accumulator, cost and stall bookkeeping, and the
// output register.
// ----------------------------------------------------------------------------
module tsls_dp
    import tsls_pkg::*;
#(
    parameter int MAX_CITIES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NUM_W-1:0]     cfg_data,
    input  logic [KIND_W-1:0]    kind,
    input  logic [IDX_W-1:0]     first_index,
    input  logic [IDX_W-1:0]     second_index,
    input  logic [DIST_W-1:0]    distance,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [COST_W-1:0]    tour_cost,
    output logic                 accepted,
    output logic [COST_W-1:0]    best_cost,
    output logic                 kick_request,
    output logic [CITY_W-1:0]    best_city
);

    localparam int AW     = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW     = $clog2(MAX_CITIES + 1);
    localparam int DAW    = 2 * AW;
    localparam int DDEPTH = 1 << DAW;

    // configuration registers
    logic [NUM_W-1:0] num_cities_reg;
    logic [LIM_W-1:0] stall_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cities_reg  <= NUM_CITIES_RST;
            stall_limit_reg <= STALL_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_CITIES:  num_cities_reg  <= cfg_data;
                CFG_STALL_LIMIT: stall_limit_reg <= cfg_data[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // active city count, clamped to the supported range
    logic [NW-1:0] n_act;

    always_comb
    begin
        if (num_cities_reg < 11'd2)
            n_act = NW'(2);
        else if (int'(num_cities_reg) > MAX_CITIES)
            n_act = NW'(MAX_CITIES);
        else
            n_act = NW'(num_cities_reg);
    end

    // range checks on the incoming word
    logic a_in_n, b_in_n, a_in_max, b_in_max, pair_ok;

    always_comb
    begin
        a_in_n   = int'(first_index) < int'(n_act);
        b_in_n   = int'(second_index) < int'(n_act);
        a_in_max = int'(first_index) < MAX_CITIES;
        b_in_max = int'(second_index) < MAX_CITIES;
        pair_ok  = a_in_n && b_in_n;
    end

    // captured word
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  a_reg, b_reg;
    logic [DIST_W-1:0] dist_in_reg;
    logic [AW-1:0]     x_reg, y_reg;
    logic              kick_ok_reg, wr_ok_reg, rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= kind;
            a_reg       <= first_index;
            b_reg       <= second_index;
            dist_in_reg <= distance;
            kick_ok_reg <= pair_ok;
            rd_ok_reg   <= a_in_n;
            wr_ok_reg   <= (kind == KIND_LOAD_DIST) ? (a_in_max && b_in_max) : a_in_max;
            if ((kind == KIND_TRY || kind == KIND_KICK) && pair_ok)
            begin
                x_reg <= AW'(first_index);
                y_reg <= AW'(second_index);
            end
            else
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
        end
    end

    // position counter shared by walk and copy
    logic [AW-1:0] pos_reg, pos_next, pos_map;

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.capture || cmd.pos_clear)
            pos_next = '0;
        else if (cmd.walk_issue || cmd.copy_issue)
            pos_next = pos_reg + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // position with the two swap positions exchanged
    always_comb
    begin
        if (pos_reg == x_reg)
            pos_map = y_reg;
        else if (pos_reg == y_reg)
            pos_map = x_reg;
        else
            pos_map = pos_reg;
    end

    // current tour memory
    logic [CITY_W-1:0] tour_mem [MAX_CITIES];
    logic [CITY_W-1:0] tour_q;
    logic [CITY_W-1:0] swap_a_reg;
    logic              tour_rd_en, tour_wr_en;
    logic [AW-1:0]     tour_rd_addr, tour_wr_addr;
    logic [CITY_W-1:0] tour_wr_data;

    always_comb
    begin
        tour_rd_en   = cmd.walk_issue || cmd.swap_rd_a || cmd.swap_rd_b || cmd.copy_issue;
        tour_rd_addr = pos_reg;
        if (cmd.walk_issue)
            tour_rd_addr = pos_map;
        else if (cmd.swap_rd_a)
            tour_rd_addr = x_reg;
        else if (cmd.swap_rd_b)
            tour_rd_addr = y_reg;

        tour_wr_en   = (cmd.wr_tour && wr_ok_reg) || cmd.swap_wr_a || cmd.swap_wr_b;
        tour_wr_addr = y_reg;
        tour_wr_data = swap_a_reg;
        if (cmd.wr_tour)
        begin
            tour_wr_addr = AW'(a_reg);
            tour_wr_data = b_reg;
        end
        else if (cmd.swap_wr_a)
        begin
            tour_wr_addr = x_reg;
            tour_wr_data = tour_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tour_wr_en)
            tour_mem[tour_wr_addr] <= tour_wr_data;
        if (tour_rd_en)
            tour_q <= tour_mem[tour_rd_addr];
    end

    // hold the first swap entry while the second is read
    always_ff @(posedge clk)
    begin
        if (cmd.swap_rd_b)
            swap_a_reg <= tour_q;
    end

    // walk stage one: city arrives, edge address formed
    logic              s1_valid_reg, s1_first_reg, s1_last_reg, close_pend_reg;
    logic [CITY_W-1:0] first_city_reg, prev_city_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            close_pend_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= cmd.walk_issue;
            close_pend_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_issue)
        begin
            s1_first_reg <= (pos_reg == '0);
            s1_last_reg  <= stat.last_pos;
        end
        if (s1_valid_reg)
        begin
            prev_city_reg <= tour_q;
            if (s1_first_reg)
                first_city_reg <= tour_q;
        end
    end

    // distance memory
    logic [DIST_W-1:0] dist_mem [DDEPTH];
    logic [DIST_W-1:0] dist_q;
    logic              d_rd_en, d_ok;
    logic [CITY_W-1:0] d_city_b;
    logic [DAW-1:0]    d_rd_addr, d_wr_addr;

    always_comb
    begin
        d_rd_en   = (s1_valid_reg && !s1_first_reg) || close_pend_reg;
        d_city_b  = close_pend_reg ? first_city_reg : tour_q;
        d_ok      = (int'(prev_city_reg) < MAX_CITIES) && (int'(d_city_b) < MAX_CITIES);
        d_rd_addr = {AW'(prev_city_reg), AW'(d_city_b)};
        d_wr_addr = {AW'(a_reg), AW'(b_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_dist && wr_ok_reg)
            dist_mem[d_wr_addr] <= dist_in_reg;
        if (d_rd_en)
            dist_q <= dist_mem[d_rd_addr];
    end

    // walk stage two: saturating accumulate
    logic              s2_valid_reg, s2_ok_reg;
    logic [COST_W-1:0] acc_reg;
    logic [COST_W:0]   acc_sum;

    assign acc_sum = {1'b0, acc_reg} + (COST_W + 1)'(dist_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= d_rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (d_rd_en)
            s2_ok_reg <= d_ok;
        if (cmd.capture)
            acc_reg <= '0;
        else if (s2_valid_reg && s2_ok_reg)
            acc_reg <= acc_sum[COST_W] ? COST_MAX : acc_sum[COST_W-1:0];
    end

    // cost and stall bookkeeping
    logic [COST_W-1:0]  current_cost_reg, lowest_cost_reg;
    logic [STALL_W-1:0] stall_count_reg;
    logic               accepted_reg, copy_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_cost_reg <= '0;
            lowest_cost_reg  <= '0;
            stall_count_reg  <= '0;
            accepted_reg     <= 1'b0;
            copy_pend_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            accepted_reg  <= 1'b0;
            copy_pend_reg <= 1'b0;
        end
        else if (cmd.start_commit)
        begin
            current_cost_reg <= acc_reg;
            lowest_cost_reg  <= acc_reg;
            stall_count_reg  <= '0;
            copy_pend_reg    <= 1'b1;
        end
        else if (cmd.try_commit)
        begin
            current_cost_reg <= acc_reg;
            stall_count_reg  <= '0;
            accepted_reg     <= 1'b1;
            if (acc_reg < lowest_cost_reg)
            begin
                lowest_cost_reg <= acc_reg;
                copy_pend_reg   <= 1'b1;
            end
        end
        else if (cmd.try_fail && stall_count_reg != STALL_MAX)
        begin
            stall_count_reg <= stall_count_reg + STALL_W'(1);
        end
    end

    // best tour memory, filled by the copy sweep
    logic [CITY_W-1:0] best_mem [MAX_CITIES];
    logic [CITY_W-1:0] best_q;
    logic              cp_valid_reg;
    logic [AW-1:0]     cp_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_valid_reg <= 1'b0;
        else
            cp_valid_reg <= cmd.copy_issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_issue)
            cp_addr_reg <= pos_reg;
        if (cp_valid_reg)
            best_mem[cp_addr_reg] <= tour_q;
        if (cmd.rd_best)
            best_q <= best_mem[AW'(a_reg)];
    end

    // output register
    logic               out_valid_reg;
    logic [COST_W-1:0]  tour_cost_reg, best_cost_reg;
    logic               accepted_out_reg, kick_reg;
    logic [CITY_W-1:0]  best_city_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            tour_cost_reg    <= (kind_reg == KIND_START || kind_reg == KIND_TRY) ?
                                acc_reg : '0;
            accepted_out_reg <= accepted_reg;
            best_cost_reg    <= lowest_cost_reg;
            kick_reg         <= stall_count_reg > {1'b0, stall_limit_reg};
            best_city_reg    <= (kind_reg == KIND_READ_BEST && rd_ok_reg) ? best_q : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tour_cost    = tour_cost_reg;
    assign accepted     = accepted_out_reg;
    assign best_cost    = best_cost_reg;
    assign kick_request = kick_reg;
    assign best_city    = best_city_reg;

    // status to the controller
    always_comb
    begin
        stat.kick_ok    = kick_ok_reg;
        stat.last_pos   = int'(pos_reg) == int'(n_act) - 1;
        stat.copy_last  = int'(pos_reg) == MAX_CITIES - 1;
        stat.pipe_busy  = s1_valid_reg || close_pend_reg || s2_valid_reg;
        stat.lt_current = acc_reg < current_cost_reg;
        stat.copy_pend  = copy_pend_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

`ifndef NO_ASSERTIONS
    // the closing edge never competes with a city for the distance port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && close_pend_reg))
        else $error("closing edge overlaps a walk city");

    // an accepted swap always clears the stall count
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.try_commit |=> stall_count_reg == '0)
        else $error("stall count not cleared after accepted swap");

    // the copy sweep never runs while the walk pipeline is active
    assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> !(s1_valid_reg || s2_valid_reg || close_pend_reg))
        else $error("best copy overlaps tour walk");
`endif

endmodule

### hw/rtl/tsls_ctrl.sv
// ----------------------------------------------------------------------------
// tsls_ctrl
// Controller: sequences one word at a time through load, walk, commit,
// swap, best-copy and result steps, driving the datapath commands.
// ----------------------------------------------------------------------------
module tsls_ctrl
    import tsls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR_DIST = 4'd1;
    localparam logic [3:0] S_WR_TOUR = 4'd2;
    localparam logic [3:0] S_WALK    = 4'd3;
    localparam logic [3:0] S_DRAIN   = 4'd4;
    localparam logic [3:0] S_SWAP_RA = 4'd5;
    localparam logic [3:0] S_SWAP_RB = 4'd6;
    localparam logic [3:0] S_SWAP_WA = 4'd7;
    localparam logic [3:0] S_SWAP_WB = 4'd8;
    localparam logic [3:0] S_COPY    = 4'd9;
    localparam logic [3:0] S_RD_BEST = 4'd10;
    localparam logic [3:0] S_RESULT  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_LOAD_DIST;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    kind_next   = kind;
                    unique case (kind)
                        KIND_LOAD_DIST:       state_next = S_WR_DIST;
                        KIND_LOAD_TOUR:       state_next = S_WR_TOUR;
                        KIND_START, KIND_TRY: state_next = S_WALK;
                        KIND_KICK:            state_next = S_SWAP_RA;
                        KIND_READ_BEST:       state_next = S_RD_BEST;
                        default:              state_next = S_RESULT;
                    endcase
                end
            end
            S_WR_DIST:
            begin
                cmd.wr_dist = 1'b1;
                state_next  = S_RESULT;
            end
            S_WR_TOUR:
            begin
                cmd.wr_tour = 1'b1;
                state_next  = S_RESULT;
            end
            S_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (stat.last_pos)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.pos_clear = 1'b1;
                    if (kind_reg == KIND_START)
                    begin
                        cmd.start_commit = 1'b1;
                        state_next       = S_COPY;
                    end
                    else if (stat.lt_current)
                    begin
                        cmd.try_commit = 1'b1;
                        state_next     = S_SWAP_RA;
                    end
                    else
                    begin
                        cmd.try_fail = 1'b1;
                        state_next   = S_RESULT;
                    end
                end
            end
            S_SWAP_RA:
            begin
                if (kind_reg == KIND_KICK && !stat.kick_ok)
                    state_next = S_RESULT;
                else
                begin
                    cmd.swap_rd_a = 1'b1;
                    state_next    = S_SWAP_RB;
                end
            end
            S_SWAP_RB:
            begin
                cmd.swap_rd_b = 1'b1;
                state_next    = S_SWAP_WA;
            end
            S_SWAP_WA:
            begin
                cmd.swap_wr_a = 1'b1;
                state_next    = S_SWAP_WB;
            end
            S_SWAP_WB:
            begin
                cmd.swap_wr_b = 1'b1;
                state_next    = stat.copy_pend ? S_COPY : S_RESULT;
            end
            S_COPY:
            begin
                cmd.copy_issue = 1'b1;
                if (stat.copy_last)
                    state_next = S_RESULT;
            end
            S_RD_BEST:
            begin
                cmd.rd_best = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a result waits while the output register is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !stat.out_free) |=> state_reg == S_RESULT)
        else $error("result left while output register busy");

    // only start and try words walk the tour
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (kind_reg == KIND_START || kind_reg == KIND_TRY))
        else $error("walk entered for a word that does not evaluate");

    // the copy sweep ends in the result step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY && stat.copy_last) |=> state_reg == S_RESULT)
        else $error("copy sweep did not finish into result");
`endif

endmodule

### hw/rtl/tour_swap_local_search_top.sv
// ----------------------------------------------------------------------------
// tour_swap_local_search_top
// Pairwise swap hill climbing over a closed tour held in on-chip memories.
//
// Input channel (in_valid/in_stall): one word per operation: distance load,
// tour load, start, try swap, kick swap or best-tour read. Output channel
// (out_valid/out_stall): exactly one result word per input word, in order.
// Configuration (cfg_valid/cfg_ready, always ready): num_cities, stall_limit;
// write only while no word is in flight.
// Words are handled one at a time. Start and try walk the tour one position
// per cycle through the tour and distance memory ports; a kept try then
// swaps its two tour entries, as a kick does, and start and a new best cost
// are followed by the best-tour copy over all MAX_CITIES positions.
// Reset clears costs, stall count and the configuration to its defaults;
// the memories hold garbage until loaded and need no clearing pass.
// A stalled output keeps its word; the next input word is taken meanwhile
// and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module tour_swap_local_search_top
    import tsls_pkg::*;
#(
    parameter int MAX_CITIES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [IDX_W-1:0]     first_index,
    input  logic [IDX_W-1:0]     second_index,
    input  logic [DIST_W-1:0]    distance,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COST_W-1:0]    tour_cost,
    output logic                 accepted,
    output logic [COST_W-1:0]    best_cost,
    output logic                 kick_request,
    output logic [CITY_W-1:0]    best_city,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NUM_W-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer
    tsls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories, walk pipeline and output register
    tsls_dp #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .first_index  (first_index),
        .second_index (second_index),
        .distance     (distance),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .tour_cost    (tour_cost),
        .accepted     (accepted),
        .best_cost    (best_cost),
        .kick_request (kick_request),
        .best_city    (best_city)
    );

endmodule
